/* sv/sphc_pkg.sv */
// Package with the shared types, register indexes and reset values of the stepper controller.
`timescale 1ns / 1ps
package sphc_pkg;

	localparam int CfgIndexBits = 3;
	localparam int CfgDataBits  = 32;
	localparam int IntervalBits = 24;
	localparam int PulseBits    = 8;
	localparam int GapBits      = 16;
	localparam int TimeoutBits  = 32;
	localparam int PulseTmrBits = 16;
	localparam int MaxAngleBits = 12;

	typedef enum logic [CfgIndexBits-1:0] {
		CFG_STEP_PERIOD    = 3'd0,
		CFG_PULSE_LEN      = 3'd1,
		CFG_HOMING_GAP     = 3'd2,
		CFG_HOMING_TIMEOUT = 3'd3,
		CFG_ANGLE_LIMIT    = 3'd4,
		CFG_REVERSE        = 3'd5
	} cfg_index_t;

	localparam logic [IntervalBits-1:0] RST_STEP_PERIOD    = 24'd8000;
	localparam logic [PulseBits-1:0]    RST_PULSE_LEN      = 8'd10;
	localparam logic [GapBits-1:0]      RST_HOMING_GAP     = 16'd2000;
	localparam logic [TimeoutBits-1:0]  RST_HOMING_TIMEOUT = 32'd5000000;
	localparam logic [MaxAngleBits-1:0] RST_ANGLE_LIMIT    = 12'd180;

	typedef enum logic [5:0] {
		PH_WAIT      = 6'b000001,
		PH_RUN_HIGH  = 6'b000010,
		PH_RUN_LOW   = 6'b000100,
		PH_HOME_HIGH = 6'b001000,
		PH_HOME_LOW  = 6'b010000,
		PH_HOME_GAP  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [IntervalBits-1:0] step_period;
		logic [PulseBits-1:0]    pulse_len;
		logic [GapBits-1:0]      homing_gap;
		logic [TimeoutBits-1:0]  homing_timeout;
		logic                    reverse;
	} timing_cfg_t;

	typedef struct packed {
		logic inc;
		logic dec;
		logic clr;
	} pos_cmd_t;

	typedef struct packed {
		logic step;
		logic dir;
		logic busy;
		logic failed;
	} status_t;

endpackage

/* sv/sphc_cfg.sv */
// Configuration register file of the stepper controller.
`timescale 1ns / 1ps
module sphc_cfg
	import sphc_pkg::*;
#(
	parameter int ANGLE_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic [CfgIndexBits-1:0] wr_index,
	input  logic [CfgDataBits-1:0]  wr_data,
	output timing_cfg_t             timing,
	output logic [ANGLE_BITS-1:0]   angle_limit
);

	timing_cfg_t             timing_q;
	logic [ANGLE_BITS-1:0]   angle_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.step_period    <= RST_STEP_PERIOD;
			timing_q.pulse_len      <= RST_PULSE_LEN;
			timing_q.homing_gap     <= RST_HOMING_GAP;
			timing_q.homing_timeout <= RST_HOMING_TIMEOUT;
			timing_q.reverse        <= 1'b0;
			angle_limit_q           <= ANGLE_BITS'(RST_ANGLE_LIMIT);
		end else if (wr_en) begin
			case (wr_index)
				CFG_STEP_PERIOD:    timing_q.step_period    <= wr_data[IntervalBits-1:0];
				CFG_PULSE_LEN:      timing_q.pulse_len      <= wr_data[PulseBits-1:0];
				CFG_HOMING_GAP:     timing_q.homing_gap     <= wr_data[GapBits-1:0];
				CFG_HOMING_TIMEOUT: timing_q.homing_timeout <= wr_data[TimeoutBits-1:0];
				CFG_ANGLE_LIMIT:    angle_limit_q <= ANGLE_BITS'(wr_data[MaxAngleBits-1:0]);
				CFG_REVERSE:        timing_q.reverse        <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	assign timing      = timing_q;
	assign angle_limit = angle_limit_q;

endmodule

/* sv/sphc_pos.sv */
// Step counter that keeps the angle as a running quotient and remainder of count*9/(5*microsteps).
`timescale 1ns / 1ps
module sphc_pos
	import sphc_pkg::*;
#(
	parameter int ANGLE_BITS = 12,
	parameter int COUNT_BITS = 16,
	parameter int MICROSTEPS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pos_cmd_t              cmd,
	input  logic [ANGLE_BITS-1:0] angle_limit,
	output logic [ANGLE_BITS-1:0] angle_cur,
	output logic [ANGLE_BITS-1:0] angle_next
);

	localparam int DIV = 5 * MICROSTEPS;
	localparam int RW  = $clog2(DIV);
	localparam int QW  = COUNT_BITS + 1;
	localparam int CW  = (QW > ANGLE_BITS) ? QW : ANGLE_BITS;
	localparam logic [63:0] CNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
	localparam logic [63:0] Q_MAX   = (CNT_MAX * 64'd9) / 64'(DIV);
	localparam logic [63:0] R_MAX   = (CNT_MAX * 64'd9) % 64'(DIV);
	localparam int K_STEP = 9 / DIV;
	localparam int B_STEP = 9 % DIV;

	logic [COUNT_BITS-1:0] cnt_q, cnt_d;
	logic [QW-1:0]         quo_q, quo_d;
	logic [RW-1:0]         rem_q, rem_d;
	logic [RW:0]           rem_up, rem_dn;

	assign rem_up = {1'b0, rem_q} + (RW+1)'(B_STEP);
	assign rem_dn = {1'b0, rem_q} - (RW+1)'(B_STEP);

	always_comb begin
		cnt_d = cnt_q;
		quo_d = quo_q;
		rem_d = rem_q;
		if (cmd.clr) begin
			cnt_d = '0;
			quo_d = '0;
			rem_d = '0;
		end else if (cmd.inc) begin
			cnt_d = cnt_q + 1'b1;
			if (cnt_q == CNT_MAX[COUNT_BITS-1:0]) begin
				quo_d = '0;
				rem_d = '0;
			end else if (rem_up >= (RW+1)'(DIV)) begin
				rem_d = RW'(rem_up - (RW+1)'(DIV));
				quo_d = quo_q + QW'(K_STEP) + 1'b1;
			end else begin
				rem_d = rem_up[RW-1:0];
				quo_d = quo_q + QW'(K_STEP);
			end
		end else if (cmd.dec) begin
			cnt_d = cnt_q - 1'b1;
			if (cnt_q == '0) begin
				quo_d = Q_MAX[QW-1:0];
				rem_d = R_MAX[RW-1:0];
			end else if (rem_dn[RW]) begin
				rem_d = RW'(rem_dn + (RW+1)'(DIV));
				quo_d = quo_q - QW'(K_STEP) - 1'b1;
			end else begin
				rem_d = rem_dn[RW-1:0];
				quo_d = quo_q - QW'(K_STEP);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
		end else begin
			cnt_q <= cnt_d;
			quo_q <= quo_d;
			rem_q <= rem_d;
		end
	end

	assign angle_cur  = (CW'(quo_q) > CW'(angle_limit)) ? angle_limit : ANGLE_BITS'(quo_q);
	assign angle_next = (CW'(quo_d) > CW'(angle_limit)) ? angle_limit : ANGLE_BITS'(quo_d);

endmodule

/* sv/sphc_ctrl.sv */
// Phase sequencer with the interval, pulse and homing timers of the stepper controller.
`timescale 1ns / 1ps
module sphc_ctrl
	import sphc_pkg::*;
#(
	parameter int ANGLE_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic [ANGLE_BITS-1:0] target_angle,
	input  logic                  limit_released,
	input  logic                  home_request,
	input  timing_cfg_t           timing,
	input  logic [ANGLE_BITS-1:0] angle_limit,
	input  logic [ANGLE_BITS-1:0] angle_cur,
	output pos_cmd_t              pos_cmd,
	output status_t               status
);

	phase_t                  phase_q, phase_d;
	logic [IntervalBits-1:0] itmr_q, itmr_d;
	logic [PulseTmrBits-1:0] ptmr_q, ptmr_d;
	logic [TimeoutBits-1:0]  htmr_q, htmr_d, htmr_chk;
	logic                    dir_q, dir_d;
	logic                    fail_q, fail_d;
	logic                    home_chk;
	logic                    up;
	logic [ANGLE_BITS-1:0]   tgt;
	pos_cmd_t                cmd;

	assign tgt = (target_angle > angle_limit) ? angle_limit : target_angle;
	assign up  = tgt > angle_cur;

	always_comb begin
		phase_d  = phase_q;
		itmr_d   = itmr_q;
		ptmr_d   = ptmr_q;
		htmr_d   = htmr_q;
		dir_d    = dir_q;
		fail_d   = fail_q;
		home_chk = 1'b0;
		cmd      = '0;
		if ((phase_q == PH_HOME_HIGH || phase_q == PH_HOME_LOW || phase_q == PH_HOME_GAP)
				&& htmr_q != '1) begin
			htmr_d = htmr_q + 1'b1;
		end
		htmr_chk = htmr_d;
		unique case (phase_q)
			PH_RUN_HIGH, PH_HOME_HIGH: begin
				if (ptmr_q >= PulseTmrBits'(timing.pulse_len)) begin
					phase_d = (phase_q == PH_RUN_HIGH) ? PH_RUN_LOW : PH_HOME_LOW;
					ptmr_d  = PulseTmrBits'(1);
				end else begin
					ptmr_d = ptmr_q + 1'b1;
				end
			end
			PH_RUN_LOW: begin
				if (ptmr_q >= PulseTmrBits'(timing.pulse_len)) begin
					phase_d = PH_WAIT;
					itmr_d  = '0;
				end else begin
					ptmr_d = ptmr_q + 1'b1;
				end
			end
			PH_HOME_LOW: begin
				if (ptmr_q >= PulseTmrBits'(timing.pulse_len)) begin
					if (timing.homing_gap == '0) begin
						home_chk = 1'b1;
					end else begin
						phase_d = PH_HOME_GAP;
						ptmr_d  = PulseTmrBits'(1);
					end
				end else begin
					ptmr_d = ptmr_q + 1'b1;
				end
			end
			PH_HOME_GAP: begin
				if (ptmr_q >= timing.homing_gap) begin
					home_chk = 1'b1;
				end else begin
					ptmr_d = ptmr_q + 1'b1;
				end
			end
			default: begin
				phase_d = PH_WAIT;
				if (home_request) begin
					htmr_d   = '0;
					htmr_chk = '0;
					fail_d   = 1'b0;
					home_chk = 1'b1;
				end else if (itmr_q > timing.step_period) begin
					itmr_d = '0;
					if (tgt != angle_cur) begin
						dir_d   = up ^ timing.reverse;
						cmd.inc = up;
						cmd.dec = !up;
						phase_d = PH_RUN_HIGH;
						ptmr_d  = PulseTmrBits'(1);
					end
				end else if (itmr_q != '1) begin
					itmr_d = itmr_q + 1'b1;
				end
			end
		endcase
		if (home_chk) begin
			priority if (htmr_chk >= timing.homing_timeout) begin
				fail_d  = 1'b1;
				phase_d = PH_WAIT;
				itmr_d  = '0;
			end else if (!limit_released) begin
				cmd.clr = 1'b1;
				phase_d = PH_WAIT;
				itmr_d  = '0;
			end else begin
				dir_d   = timing.reverse;
				phase_d = PH_HOME_HIGH;
				ptmr_d  = PulseTmrBits'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			itmr_q  <= '0;
			ptmr_q  <= '0;
			htmr_q  <= '0;
			dir_q   <= 1'b0;
			fail_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			itmr_q  <= itmr_d;
			ptmr_q  <= ptmr_d;
			htmr_q  <= htmr_d;
			dir_q   <= dir_d;
			fail_q  <= fail_d;
		end
	end

	assign pos_cmd.inc   = cmd.inc & advance;
	assign pos_cmd.dec   = cmd.dec & advance;
	assign pos_cmd.clr   = cmd.clr & advance;
	assign status.step   = (phase_d == PH_RUN_HIGH) || (phase_d == PH_HOME_HIGH);
	assign status.dir    = dir_d;
	assign status.busy   = (phase_d == PH_HOME_HIGH) || (phase_d == PH_HOME_LOW)
		|| (phase_d == PH_HOME_GAP);
	assign status.failed = fail_d;

endmodule

/* sv/stepper_position_homing_controller.sv */
// Top level of the stepper step/direction position controller with limit-switch homing.
`timescale 1ns / 1ps
// Each input transaction is one timing tick and yields exactly one output transaction that
// shows the step line, direction line, clamped angle and homing status after that tick. The
// block takes one transaction per clock while the output is not stalled: a tick is held in
// an input register, the controller state is updated from it in one pass, and the result
// lands in an output register, from which it is shown on the output port. A stall on the
// output holds the result register and the tick behind it, and the input accepts again as
// soon as space frees.
// Configuration writes take effect on the next tick and are accepted in every cycle.
module stepper_position_homing_controller
	import sphc_pkg::*;
#(
	parameter int ANGLE_BITS = 12,
	parameter int COUNT_BITS = 16,
	parameter int MICROSTEPS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// Fields from bit 0: target_angle, limit_released, home_request, zero fill.
	input  logic [((ANGLE_BITS+2+7)/8)*8-1:0] s_axis_tdata,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// Fields from bit 0: step_out, dir_out, position_angle, homing_busy, homing_failed, zero fill.
	output logic [((ANGLE_BITS+4+7)/8)*8-1:0] m_axis_tdata,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CfgIndexBits-1:0] cfg_index,
	input  logic [CfgDataBits-1:0]  cfg_data
);

	localparam int OUT_W = ((ANGLE_BITS + 4 + 7) / 8) * 8;

	logic                  valid_s1;
	logic [ANGLE_BITS-1:0] target_s1;
	logic                  limit_s1;
	logic                  req_s1;
	logic                  out_valid_q;
	logic [OUT_W-1:0]      out_data_q;
	logic                  advance;
	timing_cfg_t           timing;
	logic [ANGLE_BITS-1:0] angle_limit;
	logic [ANGLE_BITS-1:0] angle_cur;
	logic [ANGLE_BITS-1:0] angle_next;
	pos_cmd_t              pos_cmd;
	status_t               status;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			target_s1 <= s_axis_tdata[ANGLE_BITS-1:0];
			limit_s1  <= s_axis_tdata[ANGLE_BITS];
			req_s1    <= s_axis_tdata[ANGLE_BITS+1];
		end
	end

	sphc_cfg #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (cfg_valid && cfg_ready),
		.wr_index   (cfg_index),
		.wr_data    (cfg_data),
		.timing     (timing),
		.angle_limit(angle_limit)
	);

	sphc_ctrl #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.target_angle  (target_s1),
		.limit_released(limit_s1),
		.home_request  (req_s1),
		.timing        (timing),
		.angle_limit   (angle_limit),
		.angle_cur     (angle_cur),
		.pos_cmd       (pos_cmd),
		.status        (status)
	);

	sphc_pos #(
		.ANGLE_BITS(ANGLE_BITS),
		.COUNT_BITS(COUNT_BITS),
		.MICROSTEPS(MICROSTEPS)
	) u_pos (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (pos_cmd),
		.angle_limit(angle_limit),
		.angle_cur  (angle_cur),
		.angle_next (angle_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= OUT_W'({status.failed, status.busy, angle_next, status.dir,
				status.step});
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

/* sv/sphc_checker.sv */
// Port-level checker for the stepper controller and its bind to the top level.
`timescale 1ns / 1ps
module sphc_checker #(
	parameter int ANGLE_BITS = 12
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   s_axis_tvalid,
	input logic                                   s_axis_tready,
	input logic                                   m_axis_tvalid,
	input logic                                   m_axis_tready,
	input logic [((ANGLE_BITS+4+7)/8)*8-1:0]      m_axis_tdata
);

	logic out_busy;
	logic out_failed;

	assign out_busy   = m_axis_tdata[ANGLE_BITS+2];
	assign out_failed = m_axis_tdata[ANGLE_BITS+3];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output transaction changed while stalled");

	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while the output side is ready");

	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("output transaction without an input transaction two cycles earlier");

	a_busy_not_failed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_busy |-> !out_failed)
		else $error("failure flag shown during a homing run");

endmodule

bind stepper_position_homing_controller sphc_checker #(
	.ANGLE_BITS(ANGLE_BITS)
) u_sphc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

/* sim/stepper_position_homing_controller_tb.sv */
// Testbench for the stepper controller that predicts every output transaction and checks it.
`timescale 1ns / 1ps
module stepper_position_homing_controller_tb;
	import sphc_pkg::*;

	localparam int CycleLimit = 400000;

	typedef struct packed {
		logic        failed;
		logic        busy;
		logic [11:0] angle;
		logic        dir;
		logic        step;
	} tick_status_t;

	typedef struct {
		int unsigned interval;
		int unsigned width;
		int unsigned gap;
		int unsigned timeout;
		int unsigned max_ang;
		bit          rev;
	} motor_setting_t;

	class stepper_status_board;
		logic [23:0] interval_cfg;
		logic [7:0]  width_cfg;
		logic [15:0] gap_cfg;
		logic [31:0] timeout_cfg;
		logic [11:0] angle_limit_cfg;
		logic        reverse_cfg;

		phase_t      stage;
		logic [23:0] interval_tmr;
		logic [15:0] pulse_tmr;
		logic [31:0] homing_tmr;
		logic [15:0] step_count;
		logic        dir_latch;
		logic        failed;

		tick_status_t expected_status_q[$];
		int mismatches;
		int results_checked;
		int run_pulses;
		int homing_runs;
		int homed;
		int timed_out;

		function void restart();
			interval_cfg    = RST_STEP_PERIOD;
			width_cfg       = RST_PULSE_LEN;
			gap_cfg         = RST_HOMING_GAP;
			timeout_cfg     = RST_HOMING_TIMEOUT;
			angle_limit_cfg = RST_ANGLE_LIMIT;
			reverse_cfg     = 1'b0;
			stage           = PH_WAIT;
			interval_tmr    = '0;
			pulse_tmr       = '0;
			homing_tmr      = '0;
			step_count      = '0;
			dir_latch       = 1'b0;
			failed          = 1'b0;
		endfunction

		function void write_reg(cfg_index_t idx, logic [31:0] value);
			case (idx)
				CFG_STEP_PERIOD:    interval_cfg    = value[23:0];
				CFG_PULSE_LEN:      width_cfg       = value[7:0];
				CFG_HOMING_GAP:     gap_cfg         = value[15:0];
				CFG_HOMING_TIMEOUT: timeout_cfg     = value;
				CFG_ANGLE_LIMIT:    angle_limit_cfg = value[11:0];
				CFG_REVERSE:        reverse_cfg     = value[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_status_q.size();
		endfunction

		function logic [11:0] angle_now();
			int unsigned a;
			a = step_count;
			a = (a * 9) / 40;
			if (a > angle_limit_cfg)
				a = angle_limit_cfg;
			return a[11:0];
		endfunction

		function void back_to_run();
			stage = PH_WAIT;
			interval_tmr = '0;
		endfunction

		// Timeout is tested before every homing pulse, then the switch level.
		function void home_check(logic lim);
			if (homing_tmr >= timeout_cfg) begin
				failed = 1'b1;
				timed_out++;
				back_to_run();
			end else if (!lim) begin
				step_count = '0;
				homed++;
				back_to_run();
			end else begin
				dir_latch = reverse_cfg;
				stage = PH_HOME_HIGH;
				pulse_tmr = 16'd1;
			end
		endfunction

		function void predict_tick(logic [11:0] target, logic lim, logic req);
			logic [11:0] tgt;
			logic [11:0] ang;
			logic        up;
			tick_status_t st;
			tgt = (target > angle_limit_cfg) ? angle_limit_cfg : target;
			if ((stage == PH_HOME_HIGH || stage == PH_HOME_LOW || stage == PH_HOME_GAP) &&
				homing_tmr != '1)
				homing_tmr++;
			case (stage)
				PH_RUN_HIGH, PH_HOME_HIGH: begin
					if (pulse_tmr >= width_cfg) begin
						stage = (stage == PH_RUN_HIGH) ? PH_RUN_LOW : PH_HOME_LOW;
						pulse_tmr = 16'd1;
					end else begin
						pulse_tmr++;
					end
				end
				PH_RUN_LOW: begin
					if (pulse_tmr >= width_cfg)
						back_to_run();
					else
						pulse_tmr++;
				end
				PH_HOME_LOW: begin
					if (pulse_tmr >= width_cfg) begin
						if (gap_cfg == 0) begin
							home_check(lim);
						end else begin
							stage = PH_HOME_GAP;
							pulse_tmr = 16'd1;
						end
					end else begin
						pulse_tmr++;
					end
				end
				PH_HOME_GAP: begin
					if (pulse_tmr >= gap_cfg)
						home_check(lim);
					else
						pulse_tmr++;
				end
				default: begin
					stage = PH_WAIT;
					if (req) begin
						homing_tmr = '0;
						failed = 1'b0;
						homing_runs++;
						home_check(lim);
					end else if (interval_tmr > interval_cfg) begin
						ang = angle_now();
						interval_tmr = '0;
						if (tgt != ang) begin
							up = (tgt > ang);
							dir_latch = up ^ reverse_cfg;
							if (up)
								step_count++;
							else
								step_count--;
							stage = PH_RUN_HIGH;
							pulse_tmr = 16'd1;
							run_pulses++;
						end
					end else if (interval_tmr != '1) begin
						interval_tmr++;
					end
				end
			endcase
			st.step   = (stage == PH_RUN_HIGH || stage == PH_HOME_HIGH);
			st.dir    = dir_latch;
			st.angle  = angle_now();
			st.busy   = (stage == PH_HOME_HIGH || stage == PH_HOME_LOW || stage == PH_HOME_GAP);
			st.failed = failed;
			expected_status_q.push_back(st);
		endfunction

		function void compare_status(tick_status_t got);
			tick_status_t exp_st;
			results_checked++;
			if (expected_status_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected output transaction %h with nothing outstanding", got);
				return;
			end
			exp_st = expected_status_q.pop_front();
			if (got.step != exp_st.step || got.dir != exp_st.dir || got.angle != exp_st.angle ||
				got.busy != exp_st.busy || got.failed != exp_st.failed) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch at result %0d: expected step=%0b dir=%0b angle=%0d ",
						results_checked, exp_st.step, exp_st.dir, exp_st.angle,
						"busy=%0b failed=%0b, got step=%0b dir=%0b angle=%0d ",
						exp_st.busy, exp_st.failed, got.step, got.dir, got.angle,
						"busy=%0b failed=%0b", got.busy, got.failed);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CfgIndexBits-1:0] cfg_index = '0;
	logic [CfgDataBits-1:0]  cfg_data = '0;

	stepper_status_board board = new;
	bit          steady_flow = 1'b0;
	int          cycles = 0;
	int          ticks_sent = 0;
	int          settings_used = 0;
	logic [11:0] cur_target = '0;
	motor_setting_t plan[8];

	stepper_position_homing_controller DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycles,
				board.pending());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic int unsigned next_gap();
		if (steady_flow || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 13);
	endfunction

	initial begin
		int unsigned stall;
		forever begin
			stall = next_gap();
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1);
			board.compare_status(m_axis_tdata);
		end
	end

	task automatic send_tick(input logic [11:0] tgt, input logic lim, input logic req);
		int unsigned gap;
		gap = next_gap();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, req, lim, tgt};
		do @(posedge clk); while (!s_axis_tready);
		board.predict_tick(tgt, lim, req);
		ticks_sent++;
	endtask

	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, value);
	endtask

	task automatic apply_setting(input motor_setting_t s);
		write_reg(CFG_STEP_PERIOD, s.interval);
		write_reg(CFG_PULSE_LEN, s.width);
		write_reg(CFG_HOMING_GAP, s.gap);
		write_reg(CFG_HOMING_TIMEOUT, s.timeout);
		write_reg(CFG_ANGLE_LIMIT, s.max_ang);
		write_reg(CFG_REVERSE, {31'd0, s.rev});
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Mostly a steady target with occasional moves, a switch that is usually released,
	// rare homing requests, and some fully random ticks as noise.
	task automatic random_ticks(input int n, input int unsigned max_ang, input bit mid_hold);
		logic lim;
		logic req;
		for (int i = 0; i < n; i++) begin
			if (mid_hold && i == n / 2)
				wait_for_results();
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 3))
					0: cur_target = 12'($urandom_range(0, 4095));
					1: cur_target = 12'($urandom_range(0, 12));
					2: cur_target = 12'($urandom_range(0, max_ang));
					default: cur_target = cur_target ^ (12'd1 << $urandom_range(0, 11));
				endcase
			end
			lim = ($urandom_range(0, 99) >= 10);
			req = ($urandom_range(0, 49) == 0);
			if ($urandom_range(0, 19) == 0)
				send_tick(12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			else
				send_tick(cur_target, lim, req);
		end
	endtask

	initial begin
		plan[0] = '{1, 1, 0, 40, 4095, 1'b0};
		plan[1] = '{3, 2, 1, 200, 180, 1'b1};
		plan[2] = '{0, 0, 3, 1, 20, 1'b0};
		plan[3] = '{16777215, 255, 65535, 32'hFFFF_FFFF, 0, 1'b1};
		plan[4] = '{5, 3, 2, 32'hFFFF_FFFF, 4095, 1'b1};
		plan[5] = '{2, 1, 0, 0, 100, 1'b0};
		plan[6] = '{1, 4, 7, 60, 45, 1'b1};
		plan[7] = '{8000, 10, 2000, 5000000, 180, 1'b0};
		board.restart();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: field extremes and a homing request with the switch already closed.
		send_tick(12'd4095, 1'b0, 1'b0);
		send_tick(12'd0, 1'b1, 1'b0);
		send_tick(12'hAAA, 1'b1, 1'b0);
		send_tick(12'h555, 1'b0, 1'b0);
		send_tick(12'd0, 1'b0, 1'b1);
		wait_for_results();

		// Zero timeout fails at once; zero pulse width acts as one tick.
		apply_setting('{1, 0, 0, 0, 4095, 1'b1});
		send_tick(12'd0, 1'b1, 1'b1);
		repeat (6) send_tick(12'd4095, 1'b1, 1'b0);
		send_tick(12'd4095, 1'b0, 1'b1);
		wait_for_results();

		// Short timeout with no gap; requests during homing are ignored; target is clamped.
		apply_setting('{2, 1, 0, 6, 3, 1'b0});
		send_tick(12'd4095, 1'b1, 1'b1);
		repeat (9) send_tick(12'd0, 1'b1, 1'b1);
		repeat (4) send_tick(12'd4095, 1'b1, 1'b0);
		wait_for_results();

		for (int p = 0; p < 8; p++) begin
			apply_setting(plan[p]);
			steady_flow = (p % 3 == 1);
			random_ticks((p == 3 || p == 7) ? 150 : 220, plan[p].max_ang, (p % 2 == 0));
			wait_for_results();
		end
		repeat (10) @(posedge clk);

		$display("Checked %0d ticks across %0d register settings: %0d run pulses, %0d homing runs",
			ticks_sent, settings_used, board.run_pulses, board.homing_runs);
		$display("Homing reached the switch %0d times and timed out %0d times; %0d mismatches",
			board.homed, board.timed_out, board.mismatches);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
